FILE: design/tfb_pkg.sv
// Shared types and fixed-point constants of the tangent frame builder.
`timescale 1ns / 1ps
`default_nettype none
package tfb_pkg;

	// Input vector components: two's complement with four integer bits.
	localparam int COMPONENT_WIDTH = 16;
	localparam int CW_FRAC         = COMPONENT_WIDTH - 4;

	// Unit vectors come out in Q1.14.
	localparam int UNIT_W   = 16;
	localparam int FRAC_OUT = 14;
	localparam int UNIT_ONE = 1 << FRAC_OUT;

	// Degenerate threshold register.
	localparam int                 LIMIT_W     = 30;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(268435);

	// Raw bitangent before normalization holds magnitudes up to 2^18.
	localparam int BITAN_W = 20;

	// Normalizer internals: 64-bit root radicand, prescale search, divider.
	localparam int ROOT_W     = 64;
	localparam int ROOT_STEPS = ROOT_W / 2;
	localparam int K_MAX      = 16;
	localparam int K_W        = 5;
	localparam int K_TOP      = 60;
	localparam int NUM_W      = 48;
	localparam int QUO_W      = 15;

	typedef struct packed {
		logic signed [COMPONENT_WIDTH-1:0] normal_x;
		logic signed [COMPONENT_WIDTH-1:0] normal_y;
		logic signed [COMPONENT_WIDTH-1:0] normal_z;
		logic signed [COMPONENT_WIDTH-1:0] ray_x;
		logic signed [COMPONENT_WIDTH-1:0] ray_y;
		logic signed [COMPONENT_WIDTH-1:0] ray_z;
	} tfb_in_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0] unit_normal_x;
		logic signed [UNIT_W-1:0] unit_normal_y;
		logic signed [UNIT_W-1:0] unit_normal_z;
		logic signed [UNIT_W-1:0] tangent_x;
		logic signed [UNIT_W-1:0] tangent_y;
		logic signed [UNIT_W-1:0] tangent_z;
		logic signed [UNIT_W-1:0] bitangent_x;
		logic signed [UNIT_W-1:0] bitangent_y;
		logic signed [UNIT_W-1:0] bitangent_z;
		logic                     used_fallback;
	} tfb_out_t;

endpackage
`default_nettype wire

FILE: design/tangent_frame_builder_unit.sv
// Top level of the tangent frame builder: normalizers, cross products and fallback.
//
// Builds an orthonormal shading frame (unit normal, tangent, bitangent in Q1.14)
// from a surface normal and a ray direction in Q3.12. The pipeline takes one
// beat per cycle unless a valid output beat is stalled and gives one result
// beat per input beat, in order. Each of the two normalizers has a 32-stage
// square root and 15-stage dividers; the first feeds the bitangent cross
// product, rounding and degenerate test, the second the tangent cross product.
// A stall on a valid output beat holds the whole pipeline and is passed back as
// input stall. When the bitangent's squared length is zero or below the limit
// register, a perpendicular built from the normal replaces it and used_fallback
// is set. A zero normal gives an all-zero frame with used_fallback set. Write
// the limit register only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none
module tangent_frame_builder_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tfb_pkg::tfb_in_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tfb_pkg::tfb_out_t                out_data,
	input  logic                             cfg_wr_en,
	input  logic [tfb_pkg::LIMIT_W-1:0]      cfg_wr_data
);
	localparam int CW  = tfb_pkg::COMPONENT_WIDTH;
	localparam int UW  = tfb_pkg::UNIT_W;
	localparam int BW  = tfb_pkg::BITAN_W;
	localparam int PW  = UW + CW;
	localparam int DW  = PW + 1;
	localparam int L2W = 2 * BW + 2;
	localparam int TPW = 2 * UW;
	localparam int TDW = TPW + 1;
	localparam logic signed [63:0] POS_ONE = 64'(tfb_pkg::UNIT_ONE);
	localparam logic signed [63:0] NEG_ONE = -POS_ONE;

	// Round half away from zero, shift by sh.
	function automatic logic signed [63:0] rnd_away(input logic signed [63:0] x,
			input int sh);
		logic signed [63:0] half;
		half = 64'sd1 <<< (sh - 1);
		rnd_away = (x + (x[63] ? half - 64'sd1 : half)) >>> sh;
	endfunction

	function automatic logic [UW-1:0] abs_u(input logic [UW-1:0] v);
		abs_u = v[UW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [BW-1:0] sx_u(input logic [UW-1:0] v);
		sx_u = {{(BW - UW){v[UW-1]}}, v};
	endfunction

	// Global advance: the pipeline moves unless the output beat is held.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Degenerate threshold register.
	logic [tfb_pkg::LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tfb_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Normal normalizer; the ray rides along as side data.
	logic [2:0][CW-1:0] nvec;
	logic [2:0][CW-1:0] ray_in;
	logic               na_vld;
	logic [2:0][UW-1:0] na_unit;
	logic [3*CW-1:0]    na_side;
	logic [2:0][CW-1:0] ray_a;

	assign nvec[0]   = in_data.normal_x;
	assign nvec[1]   = in_data.normal_y;
	assign nvec[2]   = in_data.normal_z;
	assign ray_in[0] = in_data.ray_x;
	assign ray_in[1] = in_data.ray_y;
	assign ray_in[2] = in_data.ray_z;

	tfb_normalize #(
		.VW(CW),
		.SW(3 * CW)
	) u_norm_n (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (in_valid),
		.vec_in   (nvec),
		.side_in  (ray_in),
		.vld_out  (na_vld),
		.unit_out (na_unit),
		.side_out (na_side)
	);

	assign ray_a = na_side;

	// Stage 1: bitangent partial products and the fallback axis choice.
	logic signed [PW-1:0] bp_c  [6];
	logic signed [PW-1:0] bp_s1 [6];
	logic [2:0][UW-1:0]   u_s1;
	logic                 xgt_s1;
	logic                 vld_s1;

	always_comb begin
		bp_c[0] = $signed(na_unit[1]) * $signed(ray_a[2]);
		bp_c[1] = $signed(na_unit[2]) * $signed(ray_a[1]);
		bp_c[2] = $signed(na_unit[2]) * $signed(ray_a[0]);
		bp_c[3] = $signed(na_unit[0]) * $signed(ray_a[2]);
		bp_c[4] = $signed(na_unit[0]) * $signed(ray_a[1]);
		bp_c[5] = $signed(na_unit[1]) * $signed(ray_a[0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bp_s1  <= bp_c;
			u_s1   <= na_unit;
			xgt_s1 <= abs_u(na_unit[0]) > abs_u(na_unit[1]);
		end
	end

	// Stage 2: cross product differences.
	logic signed [DW-1:0] bd_s2 [3];
	logic [2:0][UW-1:0]   u_s2;
	logic                 xgt_s2;
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			bd_s2[0] <= bp_s1[0] - bp_s1[1];
			bd_s2[1] <= bp_s1[2] - bp_s1[3];
			bd_s2[2] <= bp_s1[4] - bp_s1[5];
			u_s2     <= u_s1;
			xgt_s2   <= xgt_s1;
		end
	end

	// Stage 3: round the bitangent to 14 fraction bits.
	logic [2:0][BW-1:0] b_s3;
	logic [2:0][UW-1:0] u_s3;
	logic               xgt_s3;
	logic               vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				b_s3[i] <= BW'(rnd_away(64'(bd_s2[i]), tfb_pkg::CW_FRAC));
			end
			u_s3   <= u_s2;
			xgt_s3 <= xgt_s2;
		end
	end

	// Stage 4: squares of the bitangent components.
	logic signed [2*BW-1:0] bsq_c [3];
	logic [2:0][2*BW-1:0]   bsq_s4;
	logic [2:0][BW-1:0]     b_s4;
	logic [2:0][UW-1:0]     u_s4;
	logic                   xgt_s4;
	logic                   vld_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bsq_c[i] = $signed(b_s3[i]) * $signed(b_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				bsq_s4[i] <= bsq_c[i];
			end
			b_s4   <= b_s3;
			u_s4   <= u_s3;
			xgt_s4 <= xgt_s3;
		end
	end

	// Stage 5: squared length.
	logic [L2W-1:0]     len2_s5;
	logic [2:0][BW-1:0] b_s5;
	logic [2:0][UW-1:0] u_s5;
	logic               xgt_s5;
	logic               vld_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s5 <= L2W'(bsq_s4[0]) + L2W'(bsq_s4[1]) + L2W'(bsq_s4[2]);
			b_s5    <= b_s4;
			u_s5    <= u_s4;
			xgt_s5  <= xgt_s4;
		end
	end

	// Stage 6: degenerate test and fallback perpendicular.
	logic               degen_c;
	logic [2:0][BW-1:0] bsel_c;
	logic [2:0][BW-1:0] b_s6;
	logic [2:0][UW-1:0] u_s6;
	logic               fb_s6;
	logic               vld_s6;

	always_comb begin
		degen_c = (len2_s5 == '0) || (len2_s5 < L2W'(limit_q));
		if (!degen_c) begin
			bsel_c = b_s5;
		end else if (xgt_s5) begin
			bsel_c[0] = ~sx_u(u_s5[2]) + 1'b1;
			bsel_c[1] = '0;
			bsel_c[2] = sx_u(u_s5[0]);
		end else begin
			bsel_c[0] = '0;
			bsel_c[1] = sx_u(u_s5[2]);
			bsel_c[2] = ~sx_u(u_s5[1]) + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s6  <= bsel_c;
			u_s6  <= u_s5;
			fb_s6 <= degen_c;
		end
	end

	// Bitangent normalizer; the unit normal and flag ride along.
	logic               nb_vld;
	logic [2:0][UW-1:0] nb_unit;
	logic [3*UW:0]      nb_side;
	logic [2:0][UW-1:0] u_nb;
	logic               fb_nb;

	tfb_normalize #(
		.VW(BW),
		.SW(3 * UW + 1)
	) u_norm_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s6),
		.vec_in   (b_s6),
		.side_in  ({fb_s6, u_s6}),
		.vld_out  (nb_vld),
		.unit_out (nb_unit),
		.side_out (nb_side)
	);

	assign u_nb  = nb_side[3*UW-1:0];
	assign fb_nb = nb_side[3*UW];

	// Stage 7: tangent partial products.
	logic signed [TPW-1:0] tp_c  [6];
	logic signed [TPW-1:0] tp_s7 [6];
	logic [2:0][UW-1:0]    bu_s7;
	logic [2:0][UW-1:0]    u_s7;
	logic                  fb_s7;
	logic                  vld_s7;

	always_comb begin
		tp_c[0] = $signed(nb_unit[1]) * $signed(u_nb[2]);
		tp_c[1] = $signed(nb_unit[2]) * $signed(u_nb[1]);
		tp_c[2] = $signed(nb_unit[2]) * $signed(u_nb[0]);
		tp_c[3] = $signed(nb_unit[0]) * $signed(u_nb[2]);
		tp_c[4] = $signed(nb_unit[0]) * $signed(u_nb[1]);
		tp_c[5] = $signed(nb_unit[1]) * $signed(u_nb[0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tp_s7 <= tp_c;
			bu_s7 <= nb_unit;
			u_s7  <= u_nb;
			fb_s7 <= fb_nb;
		end
	end

	// Stage 8: tangent differences.
	logic signed [TDW-1:0] td_s8 [3];
	logic [2:0][UW-1:0]    bu_s8;
	logic [2:0][UW-1:0]    u_s8;
	logic                  fb_s8;
	logic                  vld_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			td_s8[0] <= tp_s7[0] - tp_s7[1];
			td_s8[1] <= tp_s7[2] - tp_s7[3];
			td_s8[2] <= tp_s7[4] - tp_s7[5];
			bu_s8    <= bu_s7;
			u_s8     <= u_s7;
			fb_s8    <= fb_s7;
		end
	end

	// Stage 9: round, clamp to one; this is the output register.
	logic [2:0][UW-1:0] t_c;
	logic [2:0][UW-1:0] t_s9;
	logic [2:0][UW-1:0] bu_s9;
	logic [2:0][UW-1:0] u_s9;
	logic               fb_s9;
	logic               vld_s9;

	always_comb begin
		logic signed [63:0] r;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			r = rnd_away(64'(td_s8[i]), tfb_pkg::FRAC_OUT);
			if (r > POS_ONE) begin
				t_c[i] = POS_ONE[UW-1:0];
			end else if (r < NEG_ONE) begin
				t_c[i] = NEG_ONE[UW-1:0];
			end else begin
				t_c[i] = r[UW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s9  <= t_c;
			bu_s9 <= bu_s8;
			u_s9  <= u_s8;
			fb_s9 <= fb_s8;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= na_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= nb_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// Result beat.
	assign out_valid              = vld_s9;
	assign out_data.unit_normal_x = u_s9[0];
	assign out_data.unit_normal_y = u_s9[1];
	assign out_data.unit_normal_z = u_s9[2];
	assign out_data.tangent_x     = t_s9[0];
	assign out_data.tangent_y     = t_s9[1];
	assign out_data.tangent_z     = t_s9[2];
	assign out_data.bitangent_x   = bu_s9[0];
	assign out_data.bitangent_y   = bu_s9[1];
	assign out_data.bitangent_z   = bu_s9[2];
	assign out_data.used_fallback = fb_s9;

endmodule
`default_nettype wire

FILE: design/tfb_normalize.sv
// Pipelined 3-vector normalizer: sum of squares, prescale, square root, three dividers.
`timescale 1ns / 1ps
`default_nettype none
module tfb_normalize #(
	parameter int VW = 16,
	parameter int SW = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_in,
	input  logic [2:0][VW-1:0]                  vec_in,
	input  logic [SW-1:0]                       side_in,
	output logic                                vld_out,
	output logic [2:0][tfb_pkg::UNIT_W-1:0]     unit_out,
	output logic [SW-1:0]                       side_out
);
	localparam int SQW = 2 * VW;
	localparam int RW  = tfb_pkg::ROOT_W;
	localparam int RS  = tfb_pkg::ROOT_STEPS;
	localparam int LW  = RW / 2;
	localparam int KW  = tfb_pkg::K_W;
	localparam int NW  = tfb_pkg::NUM_W;
	localparam int QW  = tfb_pkg::QUO_W;
	localparam int DS  = QW;
	localparam int UW  = tfb_pkg::UNIT_W;

	// Stage 1: magnitudes, signs and squares.
	logic signed [SQW-1:0] sq_c [3];
	logic [2:0][VW-1:0]    mag_s1;
	logic [2:0]            sgn_s1;
	logic [2:0][SQW-1:0]   sq_s1;
	logic [SW-1:0]         side_s1;
	logic                  vld_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = $signed(vec_in[i]) * $signed(vec_in[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sgn_s1[i] <= vec_in[i][VW-1];
				mag_s1[i] <= vec_in[i][VW-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
				sq_s1[i]  <= sq_c[i];
			end
			side_s1 <= side_in;
		end
	end

	// Stage 2: exact squared length.
	logic [RW-1:0]      sum_s2;
	logic [2:0][VW-1:0] mag_s2;
	logic [2:0]         sgn_s2;
	logic [SW-1:0]      side_s2;
	logic               vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= RW'(sq_s1[0]) + RW'(sq_s1[1]) + RW'(sq_s1[2]);
			mag_s2  <= mag_s1;
			sgn_s2  <= sgn_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: prescale exponent. The threshold hits are monotonic, so the
	// number of misses is the exponent.
	logic [tfb_pkg::K_MAX-1:0] hit_c;
	logic [KW-1:0]             k_c;
	logic [RW-1:0]             sum_s3;
	logic [KW-1:0]             k_s3;
	logic                      zero_s3;
	logic [2:0][VW-1:0]        mag_s3;
	logic [2:0]                sgn_s3;
	logic [SW-1:0]             side_s3;
	logic                      vld_s3;

	always_comb begin
		for (int m = 0; m < tfb_pkg::K_MAX; m++) begin
			hit_c[m] = (sum_s2 >> (tfb_pkg::K_TOP - 2 * m)) != '0;
		end
		k_c = KW'(tfb_pkg::K_MAX - $countones(hit_c));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum_s2;
			k_s3    <= k_c;
			zero_s3 <= (sum_s2 == '0);
			mag_s3  <= mag_s2;
			sgn_s3  <= sgn_s2;
			side_s3 <= side_s2;
		end
	end

	// Square root pipeline, one result bit per stage. Index 0 holds the
	// prescaled radicand.
	logic [RW-1:0]      root_rem_s  [RS+1];
	logic [RW-1:0]      root_res_s  [RS+1];
	logic [2:0][VW-1:0] root_mag_s  [RS+1];
	logic [2:0]         root_sgn_s  [RS+1];
	logic [KW-1:0]      root_k_s    [RS+1];
	logic               root_zero_s [RS+1];
	logic [SW-1:0]      root_side_s [RS+1];
	logic               root_vld_s  [RS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			root_rem_s[0]  <= sum_s3 << {k_s3, 1'b0};
			root_res_s[0]  <= '0;
			root_mag_s[0]  <= mag_s3;
			root_sgn_s[0]  <= sgn_s3;
			root_k_s[0]    <= k_s3;
			root_zero_s[0] <= zero_s3;
			root_side_s[0] <= side_s3;
		end
	end

	for (genvar j = 0; j < RS; j++) begin : g_root
		localparam logic [RW-1:0] RBIT = RW'(1) << (RW - 2 - 2 * j);
		logic [RW-1:0] trial;

		assign trial = root_res_s[j] + RBIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				root_vld_s[j+1] <= root_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (root_rem_s[j] >= trial) begin
					root_rem_s[j+1] <= root_rem_s[j] - trial;
					root_res_s[j+1] <= (root_res_s[j] >> 1) + RBIT;
				end else begin
					root_rem_s[j+1] <= root_rem_s[j];
					root_res_s[j+1] <= root_res_s[j] >> 1;
				end
				root_mag_s[j+1]  <= root_mag_s[j];
				root_sgn_s[j+1]  <= root_sgn_s[j];
				root_k_s[j+1]    <= root_k_s[j];
				root_zero_s[j+1] <= root_zero_s[j];
				root_side_s[j+1] <= root_side_s[j];
			end
		end
	end

	// Numerators with half the root added for rounding.
	logic [LW-1:0]      root_l;
	logic [2:0][NW-1:0] num_c;

	assign root_l = root_res_s[RS][LW-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (NW'(root_mag_s[RS][i]) << (tfb_pkg::FRAC_OUT + root_k_s[RS]))
				+ NW'(root_l >> 1);
		end
	end

	// Restoring dividers, one quotient bit per stage in each lane.
	logic [2:0][NW-1:0] div_rem_s  [DS+1];
	logic [2:0][QW-1:0] div_quo_s  [DS+1];
	logic [LW-1:0]      div_den_s  [DS+1];
	logic [2:0]         div_sgn_s  [DS+1];
	logic               div_zero_s [DS+1];
	logic [SW-1:0]      div_side_s [DS+1];
	logic               div_vld_s  [DS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_s[0]  <= num_c;
			div_quo_s[0]  <= '0;
			div_den_s[0]  <= root_l;
			div_sgn_s[0]  <= root_sgn_s[RS];
			div_zero_s[0] <= root_zero_s[RS];
			div_side_s[0] <= root_side_s[RS];
		end
	end

	for (genvar d = 0; d < DS; d++) begin : g_div
		localparam int DSH = DS - 1 - d;
		logic [NW-1:0] dtrial;

		assign dtrial = NW'(div_den_s[d]) << DSH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[d+1] <= 1'b0;
			end else if (en) begin
				div_vld_s[d+1] <= div_vld_s[d];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (div_rem_s[d][i] >= dtrial) begin
						div_rem_s[d+1][i] <= div_rem_s[d][i] - dtrial;
						div_quo_s[d+1][i] <= div_quo_s[d][i] | (QW'(1) << DSH);
					end else begin
						div_rem_s[d+1][i] <= div_rem_s[d][i];
						div_quo_s[d+1][i] <= div_quo_s[d][i];
					end
				end
				div_den_s[d+1]  <= div_den_s[d];
				div_sgn_s[d+1]  <= div_sgn_s[d];
				div_zero_s[d+1] <= div_zero_s[d];
				div_side_s[d+1] <= div_side_s[d];
			end
		end
	end

	// Final stage: saturate to one, restore sign, zero vector gives zero.
	logic [2:0][UW-1:0] unit_c;
	logic [2:0][UW-1:0] fin_unit_s;
	logic [SW-1:0]      fin_side_s;
	logic               fin_vld_s;

	always_comb begin
		logic [QW-1:0] qsat;
		qsat = '0;
		for (int i = 0; i < 3; i++) begin
			qsat = (div_quo_s[DS][i] > QW'(tfb_pkg::UNIT_ONE))
				? QW'(tfb_pkg::UNIT_ONE) : div_quo_s[DS][i];
			if (div_zero_s[DS]) begin
				unit_c[i] = '0;
			end else if (div_sgn_s[DS][i]) begin
				unit_c[i] = ~UW'(qsat) + 1'b1;
			end else begin
				unit_c[i] = UW'(qsat);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_unit_s <= unit_c;
			fin_side_s <= div_side_s[DS];
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			root_vld_s[0] <= 1'b0;
			div_vld_s[0]  <= 1'b0;
			fin_vld_s     <= 1'b0;
		end else if (en) begin
			vld_s1        <= vld_in;
			vld_s2        <= vld_s1;
			vld_s3        <= vld_s2;
			root_vld_s[0] <= vld_s3;
			div_vld_s[0]  <= root_vld_s[RS];
			fin_vld_s     <= div_vld_s[DS];
		end
	end

	assign vld_out  = fin_vld_s;
	assign unit_out = fin_unit_s;
	assign side_out = fin_side_s;

endmodule
`default_nettype wire

FILE: design/tfb_checker.sv
// Port-level checks of the tangent frame builder and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tfb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input tfb_pkg::tfb_out_t out_data
);

	// A held result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// Input stall only comes from a held result beat.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// Without fallback the normal and bitangent are nonzero vectors.
	a_frame_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.used_fallback |->
		(out_data.bitangent_x != 0 || out_data.bitangent_y != 0 ||
		out_data.bitangent_z != 0) &&
		(out_data.unit_normal_x != 0 || out_data.unit_normal_y != 0 ||
		out_data.unit_normal_z != 0))
		else $error("zero vector in a frame without fallback");

	// A zero normal yields an all-zero frame with the flag set.
	a_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.unit_normal_x == 0 && out_data.unit_normal_y == 0 &&
		out_data.unit_normal_z == 0 |->
		out_data.used_fallback && out_data.tangent_x == 0 &&
		out_data.tangent_y == 0 && out_data.tangent_z == 0 &&
		out_data.bitangent_x == 0 && out_data.bitangent_y == 0 &&
		out_data.bitangent_z == 0)
		else $error("zero normal produced a nonzero frame");

endmodule

bind tangent_frame_builder_unit tfb_checker u_tfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

FILE: sim/tangent_frame_builder_unit_tb.sv
// Self-checking bench for the tangent frame builder with a scoreboard class.
`timescale 1ns / 1ps
`default_nettype none
module tangent_frame_builder_unit_tb;

	localparam int PIPE_CYCLES  = 115;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BEATS = 1500;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	tfb_pkg::tfb_in_t            in_data;
	logic                        out_valid;
	logic                        out_stall;
	tfb_pkg::tfb_out_t           out_data;
	logic                        cfg_wr_en;
	logic [tfb_pkg::LIMIT_W-1:0] cfg_wr_data;

	logic [tfb_pkg::LIMIT_W-1:0] limit_shadow;
	int                          cycle_count;

	tangent_frame_builder_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Magnitude of a signed 64-bit value.
	function automatic longint unsigned abs64(longint x);
		return (x < 0) ? longint'(0) - x : x;
	endfunction

	// Integer square root, bit-by-bit.
	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s   = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Round half away from zero after a right shift.
	function automatic longint round_away(longint x, int sh);
		longint unsigned m;
		m = (abs64(x) + (64'd1 << (sh - 1))) >> sh;
		return (x < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp_one(longint x);
		if (x > tfb_pkg::UNIT_ONE) return tfb_pkg::UNIT_ONE;
		if (x < -tfb_pkg::UNIT_ONE) return -tfb_pkg::UNIT_ONE;
		return x;
	endfunction

	// Scale a vector to unit length in Q1.14.
	function automatic void unit_vector(input longint v[3], output longint o[3]);
		longint unsigned s;
		longint unsigned len;
		longint unsigned q;
		int k;
		s = 0;
		k = 0;
		for (int i = 0; i < 3; i++) s += abs64(v[i]) * abs64(v[i]);
		if (s == 0) begin
			for (int i = 0; i < 3; i++) o[i] = 0;
			return;
		end
		while (k < 16 && s < (64'd1 << (60 - 2 * k))) k++;
		len = int_sqrt(s << (2 * k));
		for (int i = 0; i < 3; i++) begin
			q = ((abs64(v[i]) << (14 + k)) + len / 2) / len;
			if (q > tfb_pkg::UNIT_ONE) q = tfb_pkg::UNIT_ONE;
			o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
	endfunction

	// Expected frame for one input beat under the given limit.
	function automatic tfb_pkg::tfb_out_t predict_frame(tfb_pkg::tfb_in_t d,
			logic [tfb_pkg::LIMIT_W-1:0] lim);
		tfb_pkg::tfb_out_t r;
		longint n[3], ray[3], u[3], b[3], bu[3], t[3];
		longint unsigned len2;
		n[0] = d.normal_x; n[1] = d.normal_y; n[2] = d.normal_z;
		ray[0] = d.ray_x; ray[1] = d.ray_y; ray[2] = d.ray_z;
		r = '0;
		if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
			r.used_fallback = 1'b1;
			return r;
		end
		unit_vector(n, u);
		b[0] = round_away(u[1] * ray[2] - u[2] * ray[1], tfb_pkg::CW_FRAC);
		b[1] = round_away(u[2] * ray[0] - u[0] * ray[2], tfb_pkg::CW_FRAC);
		b[2] = round_away(u[0] * ray[1] - u[1] * ray[0], tfb_pkg::CW_FRAC);
		len2 = 0;
		for (int i = 0; i < 3; i++) len2 += abs64(b[i]) * abs64(b[i]);
		if (len2 == 0 || len2 < longint'(lim)) begin
			r.used_fallback = 1'b1;
			if (abs64(u[0]) > abs64(u[1])) begin
				b[0] = -u[2]; b[1] = 0; b[2] = u[0];
			end else begin
				b[0] = 0; b[1] = u[2]; b[2] = -u[1];
			end
		end
		unit_vector(b, bu);
		t[0] = clamp_one(round_away(bu[1] * u[2] - bu[2] * u[1], 14));
		t[1] = clamp_one(round_away(bu[2] * u[0] - bu[0] * u[2], 14));
		t[2] = clamp_one(round_away(bu[0] * u[1] - bu[1] * u[0], 14));
		r.unit_normal_x = u[0][15:0]; r.unit_normal_y = u[1][15:0];
		r.unit_normal_z = u[2][15:0];
		r.tangent_x = t[0][15:0]; r.tangent_y = t[1][15:0]; r.tangent_z = t[2][15:0];
		r.bitangent_x = bu[0][15:0]; r.bitangent_y = bu[1][15:0];
		r.bitangent_z = bu[2][15:0];
		return r;
	endfunction

	// Holds expected frames in order and compares arriving ones.
	class frame_scoreboard;
		tfb_pkg::tfb_out_t pending[$];
		int                mismatches;

		function void note_input(tfb_pkg::tfb_in_t d, logic [tfb_pkg::LIMIT_W-1:0] lim);
			pending.push_back(predict_frame(d, lim));
		endfunction

		function void check_frame(tfb_pkg::tfb_out_t got);
			tfb_pkg::tfb_out_t exp_f;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected frame %h", got);
				return;
			end
			exp_f = pending.pop_front();
			if (got !== exp_f) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("frame mismatch expected n=%0d,%0d,%0d t=%0d,%0d,%0d b=%0d,%0d,%0d f=%0b",
						exp_f.unit_normal_x, exp_f.unit_normal_y, exp_f.unit_normal_z,
						exp_f.tangent_x, exp_f.tangent_y, exp_f.tangent_z,
						exp_f.bitangent_x, exp_f.bitangent_y, exp_f.bitangent_z,
						exp_f.used_fallback);
					$display("               actual   n=%0d,%0d,%0d t=%0d,%0d,%0d b=%0d,%0d,%0d f=%0b",
						got.unit_normal_x, got.unit_normal_y, got.unit_normal_z,
						got.tangent_x, got.tangent_y, got.tangent_z,
						got.bitangent_x, got.bitangent_y, got.bitangent_z,
						got.used_fallback);
				end
			end
		endfunction
	endclass

	frame_scoreboard frames;

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap length: none half the time, else mostly short, sometimes long.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Output side: random stalls, check every accepted beat.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) frames.check_frame(out_data);
	end

	initial begin
		int hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			hold = gap_cycles();
			out_stall <= (hold != 0);
			repeat (hold) @(posedge clk);
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tangent_frame_builder_unit_tb failed");
			$finish;
		end
	end

	// Send one beat and wait for its acceptance.
	task automatic send_beat(tfb_pkg::tfb_in_t d);
		int gap;
		gap = gap_cycles();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		frames.note_input(d, limit_shadow);
	endtask

	// Drop valid and wait until the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames.pending.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES / 4) @(posedge clk);
	endtask

	task automatic write_limit(logic [tfb_pkg::LIMIT_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		limit_shadow = v;
	endtask

	function automatic logic [15:0] rand_comp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h8000;
		if (r == 1) return 16'h7fff;
		if (r == 2) return 16'h0000;
		if (r < 6) return 16'($signed($urandom_range(0, 8192)) - 4096);
		return 16'($urandom());
	endfunction

	// Random beat, often with the ray near parallel to the normal.
	function automatic tfb_pkg::tfb_in_t rand_beat();
		tfb_pkg::tfb_in_t d;
		d.normal_x = rand_comp(); d.normal_y = rand_comp(); d.normal_z = rand_comp();
		if ($urandom_range(0, 3) == 0) begin
			d.ray_x = d.normal_x + 16'($signed($urandom_range(0, 6)) - 3);
			d.ray_y = d.normal_y + 16'($signed($urandom_range(0, 6)) - 3);
			d.ray_z = d.normal_z + 16'($signed($urandom_range(0, 6)) - 3);
		end else begin
			d.ray_x = rand_comp(); d.ray_y = rand_comp(); d.ray_z = rand_comp();
		end
		return d;
	endfunction

	function automatic tfb_pkg::tfb_in_t mk(int nx, int ny, int nz, int rx, int ry, int rz);
		tfb_pkg::tfb_in_t d;
		d.normal_x = 16'(nx); d.normal_y = 16'(ny); d.normal_z = 16'(nz);
		d.ray_x = 16'(rx); d.ray_y = 16'(ry); d.ray_z = 16'(rz);
		return d;
	endfunction

	task automatic directed_set();
		send_beat(mk(0, 0, 0, 4096, 0, 0));
		send_beat(mk(0, 0, 0, 0, 0, 0));
		send_beat(mk(4096, 0, 0, 0, 4096, 0));
		send_beat(mk(0, 4096, 0, 0, 0, 4096));
		send_beat(mk(0, 0, 4096, 4096, 0, 0));
		send_beat(mk(4096, 0, 0, 4096, 0, 0));
		send_beat(mk(0, 4096, 0, 0, -4096, 0));
		send_beat(mk(4096, 4096, 0, 4096, 4096, 0));
		send_beat(mk(-32768, -32768, -32768, 32767, 32767, 32767));
		send_beat(mk(32767, 32767, 32767, -32768, -32768, -32768));
		send_beat(mk(32767, -32768, 1, 1, -1, 32767));
		send_beat(mk(1, 0, 0, 0, 1, 0));
		send_beat(mk(-1, -1, -1, 1, 1, 1));
		send_beat(mk(0, 0, -32768, 0, 0, 0));
		send_beat(mk(100, 20, 3000, 100, 21, 3000));
		send_beat(mk(-3000, 2999, 5, 32767, 0, -32768));
		send_beat(mk(-1, 0, 0, 0, 0, 0));
		send_beat(mk(0, -1, 0, 0, 0, -1));
	endtask

	initial begin
		logic [tfb_pkg::LIMIT_W-1:0] limits[5];
		frames       = new();
		cycle_count  = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		limit_shadow = tfb_pkg::LIMIT_RESET;
		limits[0] = '0;
		limits[1] = {tfb_pkg::LIMIT_W{1'b1}};
		limits[2] = tfb_pkg::LIMIT_RESET;
		limits[3] = tfb_pkg::LIMIT_W'(1 << 20);
		limits[4] = tfb_pkg::LIMIT_W'(1);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at the reset limit, then at both extremes.
		directed_set();
		drain();
		write_limit(limits[0]);
		directed_set();
		drain();
		write_limit(limits[1]);
		directed_set();
		drain();

		// Random phases across several limits; each phase ends idle.
		for (int p = 0; p < 5; p++) begin
			write_limit(limits[p]);
			for (int i = 0; i < RANDOM_BEATS / 5; i++) send_beat(rand_beat());
			drain();
		end

		// Final wait for any stray output.
		repeat (PIPE_CYCLES + 20) @(posedge clk);
		if (frames.mismatches == 0 && frames.pending.size() == 0) begin
			$display("tangent_frame_builder_unit_tb passed");
		end else begin
			$display("tangent_frame_builder_unit_tb failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
